### rtl/core/tdf_pkg.sv
`default_nettype none

package tdf_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int PRIME_W = 32;
  localparam int POWER_W = 5;
  localparam logic [POWER_W-1:0] POWER_MAX = 5'd31;

  localparam int PC_W = 4;
  localparam int ACT_W = 4;
  localparam int HOLD_W = 3;
  localparam int COND_W = 3;

  localparam logic [ACT_W-1:0] ACT_NONE      = 4'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD      = 4'd1;
  localparam logic [ACT_W-1:0] ACT_DIV       = 4'd2;
  localparam logic [ACT_W-1:0] ACT_CLR_E     = 4'd3;
  localparam logic [ACT_W-1:0] ACT_TAKE      = 4'd4;
  localparam logic [ACT_W-1:0] ACT_PUSH_F    = 4'd5;
  localparam logic [ACT_W-1:0] ACT_PUSH_REST = 4'd6;
  localparam logic [ACT_W-1:0] ACT_FINAL     = 4'd7;
  localparam logic [ACT_W-1:0] ACT_F_INC     = 4'd8;

  localparam logic [HOLD_W-1:0] HOLD_NONE     = 3'd0;
  localparam logic [HOLD_W-1:0] HOLD_IN       = 3'd1;
  localparam logic [HOLD_W-1:0] HOLD_DIV      = 3'd2;
  localparam logic [HOLD_W-1:0] HOLD_OUT_PEND = 3'd3;
  localparam logic [HOLD_W-1:0] HOLD_OUT      = 3'd4;

  localparam logic [COND_W-1:0] C_NEXT     = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
  localparam logic [COND_W-1:0] C_REST_LT2 = 3'd2;
  localparam logic [COND_W-1:0] C_F_GT_Q   = 3'd3;
  localparam logic [COND_W-1:0] C_REM_NZ   = 3'd4;
  localparam logic [COND_W-1:0] C_REM_Z    = 3'd5;

  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_TRY  = 4'd2;
  localparam logic [PC_W-1:0] PC_TAKE = 4'd5;
  localparam logic [PC_W-1:0] PC_INC  = 4'd9;
  localparam logic [PC_W-1:0] PC_TAIL = 4'd10;
  localparam logic [PC_W-1:0] PC_LAST = 4'd12;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [HOLD_W-1:0] hold;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic div_done;
    logic out_free;
    logic pend_v;
    logic rest_lt2;
    logic f_gt_q;
    logic rem_zero;
  } stat_t;

  function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      4'd0:    w = '{ACT_LOAD,      HOLD_IN,       C_NEXT,     PC_IDLE};
      4'd1:    w = '{ACT_NONE,      HOLD_NONE,     C_REST_LT2, PC_IDLE};
      4'd2:    w = '{ACT_DIV,       HOLD_NONE,     C_NEXT,     PC_IDLE};
      4'd3:    w = '{ACT_NONE,      HOLD_DIV,      C_F_GT_Q,   PC_TAIL};
      4'd4:    w = '{ACT_CLR_E,     HOLD_NONE,     C_REM_NZ,   PC_INC};
      4'd5:    w = '{ACT_TAKE,      HOLD_NONE,     C_NEXT,     PC_IDLE};
      4'd6:    w = '{ACT_DIV,       HOLD_NONE,     C_NEXT,     PC_IDLE};
      4'd7:    w = '{ACT_NONE,      HOLD_DIV,      C_REM_Z,    PC_TAKE};
      4'd8:    w = '{ACT_PUSH_F,    HOLD_OUT_PEND, C_NEXT,     PC_IDLE};
      4'd9:    w = '{ACT_F_INC,     HOLD_NONE,     C_ALWAYS,   PC_TRY};
      4'd10:   w = '{ACT_NONE,      HOLD_NONE,     C_REST_LT2, PC_LAST};
      4'd11:   w = '{ACT_PUSH_REST, HOLD_OUT_PEND, C_NEXT,     PC_IDLE};
      4'd12:   w = '{ACT_FINAL,     HOLD_OUT,      C_ALWAYS,   PC_IDLE};
      default: w = '{ACT_NONE,      HOLD_NONE,     C_ALWAYS,   PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/core/tdf_div.sv
`default_nettype none

module tdf_div #(
  parameter int VALUE_WIDTH = tdf_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [VALUE_WIDTH-1:0] divisor,
  output logic                        done,
  output logic [VALUE_WIDTH-1:0]      quot,
  output logic [VALUE_WIDTH-1:0]      rem
);
  import tdf_pkg::*;

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [VALUE_WIDTH-1:0] quot_r;
  logic [VALUE_WIDTH-1:0] part_r;
  logic [VALUE_WIDTH-1:0] den_r;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   diff;

  always_comb begin
    shifted = {part_r, quot_r[VALUE_WIDTH-1]};
    diff = shifted - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= CNT_W'(VALUE_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      part_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      if (!diff[VALUE_WIDTH]) begin
        part_r <= diff[VALUE_WIDTH-1:0];
        quot_r <= {quot_r[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        part_r <= shifted[VALUE_WIDTH-1:0];
        quot_r <= {quot_r[VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem = part_r;

endmodule

`default_nettype wire

### rtl/core/tdf_seq.sv
`default_nettype none

module tdf_seq (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire tdf_pkg::stat_t             stat,
  output logic                            fire,
  output logic [tdf_pkg::ACT_W-1:0]       act,
  output logic                            in_open
);
  import tdf_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  ctrl_t           w;
  logic            go;
  logic            jump;

  always_comb begin
    w = ucode_rom(pc_r);
    case (w.hold)
      HOLD_NONE:     go = 1'b1;
      HOLD_IN:       go = stat.in_valid;
      HOLD_DIV:      go = stat.div_done;
      HOLD_OUT_PEND: go = stat.out_free || !stat.pend_v;
      HOLD_OUT:      go = stat.out_free;
      default:       go = 1'b1;
    endcase
    case (w.cond)
      C_NEXT:     jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_REST_LT2: jump = stat.rest_lt2;
      C_F_GT_Q:   jump = stat.f_gt_q;
      C_REM_NZ:   jump = !stat.rem_zero;
      C_REM_Z:    jump = stat.rem_zero;
      default:    jump = 1'b0;
    endcase
    if (!go) begin
      pc_nxt = pc_r;
    end else if (jump) begin
      pc_nxt = w.target;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign fire = go;
  assign act = w.act;
  assign in_open = (w.hold == HOLD_IN);

endmodule

`default_nettype wire

### rtl/core/trial_division_factorizer.sv
// Prime factorizer by trial division.
// The input channel (in_valid, in_stall, in_value) takes one word, the number
// to factor. The result channel (out_valid, out_stall, out_prime, out_power,
// out_final_res) gives one word per prime factor, in ascending order, with
// out_final_res set on the last word of the run. Inputs of 0 and 1 give none.
// One input is worked on at a time; in_stall stays high until its run ends.
// A small microcode program steps a shared restoring divider. Each trial
// factor costs one division plus three program steps, and each time a
// factor is divided out costs another division. A prime near 2^32 needs
// about 65536 trials.
// The first result appears once the first factor has been divided out and
// the next one found, since the last word of a run can only be marked late.
// The result register holds its word while out_stall is high, and the
// program waits at the next result until the register is free.
// Reset returns the program to its idle step and empties the result
// register; no state is kept between runs.
`default_nettype none

module trial_division_factorizer #(
  parameter int VALUE_WIDTH = tdf_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [VALUE_WIDTH-1:0]        in_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tdf_pkg::PRIME_W-1:0]        out_prime,
  output logic [tdf_pkg::POWER_W-1:0]        out_power,
  output logic                               out_final_res
);
  import tdf_pkg::*;

  logic [VALUE_WIDTH-1:0] rest_r;
  logic [VALUE_WIDTH-1:0] f_r;
  logic [POWER_W-1:0]     e_r;
  logic [PRIME_W-1:0]     pend_prime_r;
  logic [POWER_W-1:0]     pend_power_r;
  logic                   pend_v_r;
  logic                   out_valid_r;
  logic [PRIME_W-1:0]     out_prime_r;
  logic [POWER_W-1:0]     out_power_r;
  logic                   out_final_r;

  stat_t                  stat;
  logic                   fire;
  logic [ACT_W-1:0]       act;
  logic                   in_open;
  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] quot;
  logic [VALUE_WIDTH-1:0] rem;
  logic                   out_free;
  logic                   emit;
  logic                   emit_final;

  tdf_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .stat    (stat),
    .fire    (fire),
    .act     (act),
    .in_open (in_open)
  );

  tdf_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rest_r),
    .divisor  (f_r),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    stat.in_valid = in_valid;
    stat.div_done = div_done;
    stat.out_free = out_free;
    stat.pend_v = pend_v_r;
    stat.rest_lt2 = (rest_r < VALUE_WIDTH'(2));
    stat.f_gt_q = (f_r > quot);
    stat.rem_zero = (rem == '0);
    div_start = fire && (act == ACT_DIV);
    emit_final = fire && (act == ACT_FINAL);
    emit = emit_final
        || (fire && pend_v_r && ((act == ACT_PUSH_F) || (act == ACT_PUSH_REST)));
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      case (act)
        ACT_LOAD: begin
          rest_r <= in_value;
          f_r <= VALUE_WIDTH'(2);
        end
        ACT_CLR_E: e_r <= '0;
        ACT_TAKE: begin
          rest_r <= quot;
          e_r <= (e_r == POWER_MAX) ? e_r : e_r + POWER_W'(1);
        end
        ACT_PUSH_F: begin
          pend_prime_r <= PRIME_W'(f_r);
          pend_power_r <= e_r;
        end
        ACT_PUSH_REST: begin
          pend_prime_r <= PRIME_W'(rest_r);
          pend_power_r <= POWER_W'(1);
        end
        ACT_F_INC: f_r <= f_r + VALUE_WIDTH'(1);
        default: ;
      endcase
    end
    if (emit) begin
      out_prime_r <= pend_prime_r;
      out_power_r <= pend_power_r;
      out_final_r <= emit_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire && ((act == ACT_LOAD) || (act == ACT_FINAL))) begin
        pend_v_r <= 1'b0;
      end else if (fire && ((act == ACT_PUSH_F) || (act == ACT_PUSH_REST))) begin
        pend_v_r <= 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall = !in_open;
  assign out_valid = out_valid_r;
  assign out_prime = out_prime_r;
  assign out_power = out_power_r;
  assign out_final_res = out_final_r;

endmodule

`default_nettype wire
